// ----- design/sfp_pkg.sv -----
package sfp_pkg;

  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] LEN_HIGH   = 8'h00;
  localparam logic [7:0] LEN_LOW    = 8'h14;
  localparam logic [7:0] SUM_GOOD   = 8'hFF;

  localparam int unsigned IdxW       = 5;
  localparam int unsigned ValueCount = 5;
  localparam int unsigned SlotW      = 3;

  localparam logic [IdxW-1:0] BODY_LAST   = IdxW'(20);
  localparam logic [IdxW-1:0] VALUE_FIRST = IdxW'(10);
  localparam logic [IdxW-1:0] VALUE_END   = IdxW'(20);

  // slot order of the value array
  localparam logic [SlotW-1:0] SLOT_Z    = SlotW'(0);
  localparam logic [SlotW-1:0] SLOT_Y    = SlotW'(1);
  localparam logic [SlotW-1:0] SLOT_X    = SlotW'(2);
  localparam logic [SlotW-1:0] SLOT_EMG1 = SlotW'(3);
  localparam logic [SlotW-1:0] SLOT_EMG2 = SlotW'(4);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN1 = 2'd1,
    PH_LEN2 = 2'd2,
    PH_BODY = 2'd3
  } phase_e;

  typedef logic [15:0] value_t;

  typedef struct packed {
    logic   frame_ok;
    value_t [ValueCount-1:0] values;
  } result_t;

endpackage

// ----- design/sensor_frame_parser_unit.sv -----
// channel  dir  handshake               payload
// in       in   in_valid_i/in_ready_o   rx_byte_i[7:0]
// out      out  out_valid_o/out_ready_i frame_ok_o, accel_x/y/z_o, emg_one/two_o [15:0]
//
// One byte per cycle; the frame state and the result register update in the
// cycle a byte is taken, so a result shows on the cycle after its last byte.
// Reset (rst_ni low, async) returns to hunting and clears the sum and the parser's values.
// in_ready_o drops only while a result sits unread and out_ready_i is low.
module sensor_frame_parser_unit
  import sfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        frame_ok_o,
  output logic [15:0] accel_x_o,
  output logic [15:0] accel_y_o,
  output logic [15:0] accel_z_o,
  output logic [15:0] emg_one_o,
  output logic [15:0] emg_two_o
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign accept = in_valid_i && in_ready_o;

  sfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .can_take_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_res)
  );

  assign frame_ok_o = out_res.frame_ok;
  assign accel_x_o  = out_res.values[SLOT_X];
  assign accel_y_o  = out_res.values[SLOT_Y];
  assign accel_z_o  = out_res.values[SLOT_Z];
  assign emg_one_o  = out_res.values[SLOT_EMG1];
  assign emg_two_o  = out_res.values[SLOT_EMG2];

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_result_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> accept)
    else $error("result raised without an accepted word");

  a_rise_from_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(accept))
    else $error("result appeared without a preceding word");

endmodule

// ----- design/sfp_parser.sv -----
module sfp_parser
  import sfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e            phase_q, phase_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [7:0]        sum_q, sum_d;
  value_t [ValueCount-1:0] staged_q, staged_d;
  value_t [ValueCount-1:0] held_q, held_d;

  logic [IdxW-1:0]   rel;
  logic [SlotW-1:0]  slot;
  logic              in_values;
  logic              last_byte;
  logic              ok;
  logic [7:0]        sum_add;

  assign sum_add   = sum_q + rx_byte_i;
  assign rel       = idx_q - VALUE_FIRST;
  assign slot      = rel[SlotW:1];
  assign in_values = (idx_q >= VALUE_FIRST) && (idx_q < VALUE_END);
  assign last_byte = (idx_q >= BODY_LAST);
  assign ok        = (sum_add == SUM_GOOD);

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    staged_d    = staged_q;
    held_d      = held_q;
    res_valid_o = 1'b0;
    res_o.frame_ok = ok;
    res_o.values   = ok ? staged_q : held_q;
    if (accept_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == START_BYTE) phase_d = PH_LEN1;
        end
        PH_LEN1: begin
          phase_d = (rx_byte_i == LEN_HIGH) ? PH_LEN2 : PH_HUNT;
        end
        PH_LEN2: begin
          if (rx_byte_i == LEN_LOW) begin
            phase_d = PH_BODY;
            idx_d   = '0;
            sum_d   = '0;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_BODY: begin
          sum_d = sum_add;
          if (in_values) begin
            for (int k = 0; k < ValueCount; k++) begin
              if (slot == SlotW'(k)) begin
                if (rel[0]) staged_d[k][7:0]  = rx_byte_i;
                else        staged_d[k][15:8] = rx_byte_i;
              end
            end
          end
          if (last_byte) begin
            if (ok) held_d = staged_q;
            phase_d     = PH_HUNT;
            idx_d       = '0;
            sum_d       = '0;
            res_valid_o = 1'b1;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      idx_q    <= '0;
      sum_q    <= '0;
      staged_q <= '0;
      held_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      sum_q    <= sum_d;
      staged_q <= staged_d;
      held_q   <= held_d;
    end
  end

endmodule

// ----- design/sfp_out_reg.sv -----
module sfp_out_reg
  import sfp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    can_take_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign can_take_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) valid_d = 1'b0;
    if (res_valid_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) data_q <= res_i;
  end

endmodule
